@@ hw/rtl/mrre_pkg.sv @@
// Package: shared types and constants of the mesh route receive engine.
package mrre_pkg;

  localparam int unsigned NodeSlotsDef = 256;
  localparam logic [7:0] Bcast = 8'hFF;
  localparam logic [7:0] CtrlClear = 8'd1;
  localparam logic [7:0] NodeAddrRst = 8'd1;
  localparam logic [7:0] MaxHopsRst = 8'd30;
  localparam logic signed [8:0] NearRssi = -9'sd80;
  localparam int unsigned FlagAckBit = 7;
  localparam int unsigned FlagArpBit = 6;
  localparam int unsigned FlagTestBit = 5;

  // Configuration register indexes
  localparam logic CfgNodeAddr = 1'b0;
  localparam logic CfgMaxHops = 1'b1;

  typedef enum logic [2:0] {
    ActDiscard = 3'd0,
    ActDeliver = 3'd1,
    ActForward = 3'd2,
    ActNoRoute = 3'd3,
    ActDup     = 3'd4,
    ActControl = 3'd5,
    ActLookup  = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    AckNone    = 3'd0,
    AckOk      = 3'd1,
    AckNoRoute = 3'd2,
    AckBcast   = 3'd3,
    AckArp     = 3'd4
  } ack_e;

  typedef enum logic [3:0] {
    StClrAll, StClrRt, StIdle, StDispatch, StCtrl, StRdFrom, StEvFrom, StRdSrc, StEvSrc,
    StRdDst, StEvDst
  } state_e;

  typedef enum logic [1:0] {
    SelFrom, SelSrc, SelDst
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    eval_from;
    logic    eval_src;
    logic    do_ctrl;
    logic    do_final;
    logic    clr_rt;
    logic    clr_seen;
  } dp_cmd_t;

  typedef struct packed {
    logic lookup;
    logic test;
    logic clear;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/mrre_ctrl.sv @@
// Controller: sequences table reads, learning writes and result load per transaction.
module mrre_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrre_pkg::dp_stat_t stat_i,
  output mrre_pkg::dp_cmd_t  cmd_o
);

  mrre_pkg::state_e state_q, state_d;

  // Reset starts with a clearing pass over both tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrre_pkg::StClrAll;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mrre_pkg::StClrAll:   if (stat_i.clr_last) state_d = mrre_pkg::StIdle;
      mrre_pkg::StClrRt:    if (stat_i.clr_last) state_d = mrre_pkg::StIdle;
      mrre_pkg::StIdle:     if (in_valid_i) state_d = mrre_pkg::StDispatch;
      mrre_pkg::StDispatch: begin
        if (stat_i.lookup) state_d = mrre_pkg::StRdDst;
        else if (stat_i.test) state_d = mrre_pkg::StCtrl;
        else state_d = mrre_pkg::StRdFrom;
      end
      mrre_pkg::StCtrl: begin
        if (stat_i.out_free) state_d = stat_i.clear ? mrre_pkg::StClrRt : mrre_pkg::StIdle;
      end
      mrre_pkg::StRdFrom:   state_d = mrre_pkg::StEvFrom;
      mrre_pkg::StEvFrom:   state_d = mrre_pkg::StRdSrc;
      mrre_pkg::StRdSrc:    state_d = mrre_pkg::StEvSrc;
      mrre_pkg::StEvSrc:    state_d = mrre_pkg::StRdDst;
      mrre_pkg::StRdDst:    state_d = mrre_pkg::StEvDst;
      mrre_pkg::StEvDst:    if (stat_i.out_free) state_d = mrre_pkg::StIdle;
      default:              state_d = mrre_pkg::StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = mrre_pkg::SelFrom;
    in_ready_o = 1'b0;
    case (state_q)
      mrre_pkg::StClrAll: begin
        cmd_o.clr_rt   = 1'b1;
        cmd_o.clr_seen = 1'b1;
      end
      mrre_pkg::StClrRt:  cmd_o.clr_rt = 1'b1;
      mrre_pkg::StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      mrre_pkg::StCtrl:   cmd_o.do_ctrl = stat_i.out_free;
      mrre_pkg::StRdFrom: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = mrre_pkg::SelFrom;
      end
      mrre_pkg::StEvFrom: cmd_o.eval_from = 1'b1;
      mrre_pkg::StRdSrc: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = mrre_pkg::SelSrc;
      end
      mrre_pkg::StEvSrc:  cmd_o.eval_src = 1'b1;
      mrre_pkg::StRdDst: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = mrre_pkg::SelDst;
      end
      mrre_pkg::StEvDst:  cmd_o.do_final = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/mrre_dp.sv @@
// Datapath: frame registers, route and seen tables, decision logic and result register.
module mrre_dp #(
  parameter int unsigned NodeSlots = mrre_pkg::NodeSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_cmd_i,
  input  logic [95:0]        in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         out_action_o,
  output logic [55:0]        out_data_o,
  input  mrre_pkg::dp_cmd_t  cmd_i,
  output mrre_pkg::dp_stat_t stat_o
);

  localparam int unsigned IdxW = $clog2(NodeSlots);

  // Configuration
  logic [7:0] node_addr_q, max_hops_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= mrre_pkg::NodeAddrRst;
      max_hops_q  <= mrre_pkg::MaxHopsRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mrre_pkg::CfgNodeAddr) node_addr_q <= cfg_data_i;
      if (cfg_idx_i == mrre_pkg::CfgMaxHops) max_hops_q <= cfg_data_i;
    end
  end

  // Frame header registers
  logic cmd_q;
  logic [7:0] from_q, to_q, lid_q, lflags_q, code_q, rsrc_q, rdst_q, rhops_q, rid_q, rflags_q;
  logic signed [8:0] rssi_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q    <= in_cmd_i;
      from_q   <= in_data_i[7:0];
      to_q     <= in_data_i[15:8];
      lid_q    <= in_data_i[23:16];
      lflags_q <= in_data_i[31:24];
      code_q   <= in_data_i[39:32];
      rsrc_q   <= in_data_i[47:40];
      rdst_q   <= in_data_i[55:48];
      rhops_q  <= in_data_i[63:56];
      rid_q    <= in_data_i[71:64];
      rflags_q <= in_data_i[79:72];
      rssi_q   <= $signed(in_data_i[88:80]);
    end
  end

  function automatic logic in_range(input logic [7:0] n);
    in_range = ({1'b0, n} < 9'(NodeSlots));
  endfunction

  // Clearing pass index, one entry per cycle
  logic [IdxW-1:0] wipe_idx_q, wipe_idx_d;
  logic            clr_last;
  assign clr_last   = (wipe_idx_q == IdxW'(NodeSlots - 1));
  assign wipe_idx_d = clr_last ? '0 : wipe_idx_q + IdxW'(1);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_idx_q <= '0;
    end else if (cmd_i.clr_rt) begin
      wipe_idx_q <= wipe_idx_d;
    end
  end

  // Table storage: hop in low byte, strength in high byte
  logic [15:0] rt_mem [NodeSlots];
  logic [7:0]  seen_mem [NodeSlots];
  logic [15:0] rt_rd_q;
  logic [7:0]  seen_rd_q;
  logic [7:0]  rd_node, rd_node_q;

  always_comb begin
    case (cmd_i.rd_sel)
      mrre_pkg::SelFrom: rd_node = from_q;
      mrre_pkg::SelSrc:  rd_node = rsrc_q;
      mrre_pkg::SelDst:  rd_node = rdst_q;
      default:           rd_node = from_q;
    endcase
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rt_rd_q   <= rt_mem[rd_node[IdxW-1:0]];
      rd_node_q <= rd_node;
      if (cmd_i.rd_sel == mrre_pkg::SelFrom) seen_rd_q <= seen_mem[rd_node[IdxW-1:0]];
    end
  end

  // Decoded read values; nodes beyond the table read as empty
  logic       rt_hit;
  logic [7:0] hop_rd, str_rd, route_rd;
  assign rt_hit   = in_range(rd_node_q);
  assign hop_rd   = rt_hit ? rt_rd_q[7:0] : 8'd0;
  assign str_rd   = rt_hit ? rt_rd_q[15:8] : 8'hFF;
  assign route_rd = (rd_node_q == mrre_pkg::Bcast) ? mrre_pkg::Bcast : hop_rd;

  // Direct route learning decision
  logic signed [9:0] neg_str, rssi_w;
  logic [8:0] neg_rssi;
  logic [7:0] str_new;
  logic learn_from, learn_src, ack_f, arp_f;
  assign ack_f    = lflags_q[mrre_pkg::FlagAckBit];
  assign arp_f    = lflags_q[mrre_pkg::FlagArpBit];
  assign neg_str  = 10'sd0 - $signed({2'b00, str_rd});
  assign rssi_w   = {rssi_q[8], rssi_q};
  assign neg_rssi = 9'd0 - rssi_q;
  always_comb begin
    if (!rssi_q[8]) str_new = 8'd0;
    else if (rssi_q <= -9'sd255) str_new = 8'hFF;
    else str_new = neg_rssi[7:0];
  end
  assign learn_from = (route_rd == 8'd0) || ((route_rd != from_q) &&
                      ((rssi_q > mrre_pkg::NearRssi) || (rssi_w > neg_str)));
  assign learn_src  = !ack_f && !arp_f && (route_rd == 8'd0);

  // Route table write; the clearing pass has priority
  logic       rt_we;
  logic [7:0] rt_wnode;
  assign rt_wnode = cmd_i.eval_from ? from_q : rsrc_q;
  assign rt_we    = ((cmd_i.eval_from && learn_from) || (cmd_i.eval_src && learn_src)) &&
                    (rt_wnode != mrre_pkg::Bcast) && in_range(rt_wnode);
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_rt) begin
      rt_mem[wipe_idx_q] <= {8'hFF, 8'h00};
    end else if (rt_we) begin
      rt_mem[rt_wnode[IdxW-1:0]] <= {cmd_i.eval_from ? str_new : 8'd0, from_q};
    end
  end

  // Final decision
  logic [7:0] seen_val;
  logic       dup, seen_we;
  mrre_pkg::action_e act;
  mrre_pkg::ack_e    ack;
  logic [7:0] nh, nhops;
  logic       deliver;
  assign seen_val = in_range(from_q) ? seen_rd_q : 8'd0;
  assign dup      = (lid_q == seen_val);

  always_comb begin
    act = mrre_pkg::ActDiscard;
    ack = mrre_pkg::AckNone;
    nh = 8'd0;
    nhops = 8'd0;
    deliver = 1'b0;
    if (cmd_q) begin
      act = mrre_pkg::ActLookup;
      nh  = route_rd;
    end else if (ack_f) begin
      act = mrre_pkg::ActDiscard;
    end else if (arp_f) begin
      if (to_q == node_addr_q) ack = mrre_pkg::AckBcast;
      else if (to_q == mrre_pkg::Bcast && (rdst_q == 8'd0 || route_rd != 8'd0))
        ack = mrre_pkg::AckArp;
    end else begin
      if (to_q == node_addr_q)
        ack = (to_q == rdst_q || route_rd != 8'd0) ? mrre_pkg::AckOk : mrre_pkg::AckNoRoute;
      if (dup) begin
        act = mrre_pkg::ActDup;
      end else if (rdst_q == node_addr_q || rdst_q == mrre_pkg::Bcast) begin
        act = mrre_pkg::ActDeliver;
        deliver = 1'b1;
      end else if (to_q == node_addr_q && route_rd != from_q && rhops_q < max_hops_q) begin
        if (route_rd == 8'd0) begin
          act = mrre_pkg::ActNoRoute;
        end else begin
          act   = mrre_pkg::ActForward;
          nh    = route_rd;
          nhops = rhops_q + 8'd1;
        end
      end
    end
  end

  // Seen table write; cleared only by the pass after reset
  assign seen_we = (cmd_i.do_ctrl || (cmd_i.do_final && !cmd_q && !ack_f && !arp_f && !dup)) &&
                   in_range(from_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_seen) begin
      seen_mem[wipe_idx_q] <= 8'd0;
    end else if (seen_we) begin
      seen_mem[from_q[IdxW-1:0]] <= lid_q;
    end
  end

  // Result register
  logic out_valid_q;
  logic [2:0] out_action_q;
  logic [55:0] out_data_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.lookup   = cmd_q;
  assign stat_o.test     = (to_q == mrre_pkg::Bcast) && lflags_q[mrre_pkg::FlagTestBit];
  assign stat_o.clear    = (code_q == mrre_pkg::CtrlClear);
  assign stat_o.clr_last = clr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.do_ctrl || cmd_i.do_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_ctrl) begin
      out_action_q <= mrre_pkg::ActControl;
      out_data_q   <= '0;
    end else if (cmd_i.do_final) begin
      out_action_q <= act;
      out_data_q   <= {5'd0,
                       deliver ? rflags_q : 8'd0,
                       deliver ? rid_q : 8'd0,
                       deliver ? rdst_q : 8'd0,
                       deliver ? rsrc_q : 8'd0,
                       nhops, nh, ack};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_action_o = out_action_q;
  assign out_data_o   = out_data_q;

endmodule

@@ hw/rtl/mesh_route_receive_engine_unit.sv @@
// Top level of the mesh route receive engine.
// Usage:
//  - Slave stream takes one frame header or a route lookup per transaction;
//    tuser is the command (0 frame, 1 lookup), tdata the header fields.
//  - Master stream gives one result per transaction; tuser is the frame
//    action, tdata the ack kind, hop, hop count and delivered header.
//  - Configuration: cfg_we_i writes node address (index 0) or max hops
//    (index 1) from cfg_data_i; write only while the engine is idle.
//  - Steps: after acceptance a lookup passes a dispatch step, one read and
//    an evaluate step; a control frame a dispatch and a control step; other
//    frames a dispatch step and the walk of the single-port tables (up to
//    three registered reads, each followed by an evaluate step). The engine
//    then returns to idle, where it takes the next one.
//  - One transaction is in work at a time; a new one is taken as soon as
//    the previous result sits in the output register, even if not taken.
//  - A stalled receiver holds the result; the engine waits in its final
//    step until the output register frees.
//  - Reset runs a clearing pass over all NodeSlots entries of both tables
//    with s_axis_tready low; a test-control clear runs the same pass over the
//    route table after its result is loaded.
module mesh_route_receive_engine_unit #(
  parameter int unsigned NodeSlots = mrre_pkg::NodeSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: link_from, link_to, link_id, link_flags, control_code, routed_source,
  //        routed_dest, routed_hops, routed_id, routed_flags, signal_rssi[88:80]
  input  logic [95:0] s_axis_tdata,
  // tuser: command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: ack_kind[2:0], fwd_hop, new_hops, delivered_source, delivered_dest,
  //        delivered_id, delivered_flags[50:43]
  output logic [55:0] m_axis_tdata,
  // tuser: frame_action
  output logic [2:0]  m_axis_tuser
);

  mrre_pkg::dp_cmd_t  cmd;
  mrre_pkg::dp_stat_t stat;

  mrre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mrre_dp #(.NodeSlots(NodeSlots)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_action_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

@@ hw/rtl/mrre_checker.sv @@
// Port checker for the mesh route receive engine, bound to the top level.
module mrre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // One transaction in work at a time
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // Lookup answers carry no ack
  a_lookup_noack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == mrre_pkg::ActLookup |->
      m_axis_tdata[2:0] == mrre_pkg::AckNone)
    else $error("lookup with ack");

  // Forward always names a next hop
  a_fwd_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == mrre_pkg::ActForward |-> m_axis_tdata[10:3] != 8'd0)
    else $error("forward without next hop");

endmodule

bind mesh_route_receive_engine_unit mrre_checker u_mrre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
